// ===== hw/rtl/cfr_pkg.sv =====
// ----------------------------------------------------------------------------
// cfr_pkg
// Types and constants shared by the checksummed frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package cfr_pkg;

  // Size of the message buffer that bounds the length byte.
  localparam int MESSAGE_SIZE = 256;
  localparam int LEN_LIMIT    = MESSAGE_SIZE - 3;

  localparam logic [7:0] RESEND_MASK = 8'h80;
  localparam logic [6:0] CODE_MASK   = 7'h7f;

  // Fixed-frame header codes outside the printable range.
  localparam logic [6:0] HDR_NUL     = 7'h00;
  localparam logic [6:0] HDR_EOT     = 7'h04;
  localparam logic [6:0] HDR_BEL     = 7'h07;
  localparam logic [6:0] HDR_ETB     = 7'h17;
  // Lowest printable header code, lowest variable-length header code.
  localparam logic [6:0] HDR_PRINT   = 7'h20;
  localparam logic [6:0] HDR_VAR     = 7'h60;

  typedef enum logic [3:0] {
    PH_HEADER    = 4'b0001,
    PH_FIXED_SUM = 4'b0010,
    PH_LENGTH    = 4'b0100,
    PH_PAYLOAD   = 4'b1000
  } phase_t;

  typedef struct packed {
    logic       ack;
    logic       checksum_bad;
    logic [6:0] frame_code;
    logic       resend;
    logic [7:0] payload_count;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/checksummed_frame_receiver_top.sv =====
// ----------------------------------------------------------------------------
// checksummed_frame_receiver_top
// Byte-stream frame receiver with 8-bit additive checksum check.
// ----------------------------------------------------------------------------
// Takes one received word per cycle while results drain and returns exactly
// one result word for every input word, in the cycle after acceptance. Frames are
// header [length payload...] checksum; the checksum is the wrapping 8-bit sum
// of all earlier frame bytes. A match raises ack with the header code, resend
// bit and payload length; a mismatch raises checksum_bad. All decoding and the
// 8-bit add happen in the accepting cycle; a single output register holds the
// result, and a new word is taken whenever that register is empty or being
// drained, so the sustained rate is one word per cycle.
`default_nettype none

module checksummed_frame_receiver_top (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_rx_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            out_ack,
  output logic            out_checksum_bad,
  output logic [6:0]      out_frame_code,
  output logic            out_resend,
  output logic [7:0]      out_payload_count
);

  cfr_pkg::phase_t  phase_r, phase_nxt;
  logic [7:0]       held_header_r, held_header_nxt;
  logic [7:0]       expected_count_r, expected_count_nxt;
  logic [7:0]       seen_count_r, seen_count_nxt;
  logic [7:0]       running_sum_r, running_sum_nxt;
  cfr_pkg::result_t result_r, result_nxt;
  logic             out_valid_r;
  logic             accept;

  logic [6:0] code;
  logic       hdr_ok;
  logic       hdr_var;
  logic       len_too_big;
  logic       sum_match;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  assign code        = in_rx_byte[6:0] & cfr_pkg::CODE_MASK;
  assign hdr_ok      = (code == cfr_pkg::HDR_NUL) || (code == cfr_pkg::HDR_EOT) ||
                       (code == cfr_pkg::HDR_BEL) || (code == cfr_pkg::HDR_ETB) ||
                       (code >= cfr_pkg::HDR_PRINT);
  assign hdr_var     = code >= cfr_pkg::HDR_VAR;
  assign len_too_big = {1'b0, in_rx_byte} >= 9'(cfr_pkg::LEN_LIMIT);
  assign sum_match   = in_rx_byte == running_sum_r;

  always_comb begin
    phase_nxt          = phase_r;
    held_header_nxt    = held_header_r;
    expected_count_nxt = expected_count_r;
    seen_count_nxt     = seen_count_r;
    running_sum_nxt    = running_sum_r;
    result_nxt         = '0;

    unique case (phase_r)
      cfr_pkg::PH_HEADER: begin
        if (hdr_ok) begin
          held_header_nxt    = in_rx_byte;
          running_sum_nxt    = in_rx_byte;
          expected_count_nxt = '0;
          seen_count_nxt     = '0;
          phase_nxt          = hdr_var ? cfr_pkg::PH_LENGTH : cfr_pkg::PH_FIXED_SUM;
        end
      end
      cfr_pkg::PH_LENGTH: begin
        if (len_too_big) begin
          phase_nxt          = cfr_pkg::PH_HEADER;
          held_header_nxt    = '0;
          expected_count_nxt = '0;
          seen_count_nxt     = '0;
          running_sum_nxt    = '0;
        end else begin
          expected_count_nxt = in_rx_byte;
          seen_count_nxt     = '0;
          running_sum_nxt    = running_sum_r + in_rx_byte;
          phase_nxt          = cfr_pkg::PH_PAYLOAD;
        end
      end
      cfr_pkg::PH_FIXED_SUM, cfr_pkg::PH_PAYLOAD: begin
        if (phase_r == cfr_pkg::PH_PAYLOAD && seen_count_r < expected_count_r) begin
          running_sum_nxt = running_sum_r + in_rx_byte;
          seen_count_nxt  = seen_count_r + 8'd1;
        end else begin
          // final byte of the frame: compare and return to header hunt
          if (sum_match) begin
            result_nxt.ack           = 1'b1;
            result_nxt.frame_code    = held_header_r[6:0] & cfr_pkg::CODE_MASK;
            result_nxt.resend        = |(held_header_r & cfr_pkg::RESEND_MASK);
            result_nxt.payload_count = expected_count_r;
          end else begin
            result_nxt.checksum_bad  = 1'b1;
          end
          phase_nxt          = cfr_pkg::PH_HEADER;
          held_header_nxt    = '0;
          expected_count_nxt = '0;
          seen_count_nxt     = '0;
          running_sum_nxt    = '0;
        end
      end
      default: begin
        phase_nxt = cfr_pkg::PH_HEADER;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r          <= cfr_pkg::PH_HEADER;
      held_header_r    <= '0;
      expected_count_r <= '0;
      seen_count_r     <= '0;
      running_sum_r    <= '0;
      out_valid_r      <= 1'b0;
    end else begin
      if (accept) begin
        phase_r          <= phase_nxt;
        held_header_r    <= held_header_nxt;
        expected_count_r <= expected_count_nxt;
        seen_count_r     <= seen_count_nxt;
        running_sum_r    <= running_sum_nxt;
        out_valid_r      <= 1'b1;
      end else if (out_ready) begin
        out_valid_r      <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_ack           = result_r.ack;
  assign out_checksum_bad  = result_r.checksum_bad;
  assign out_frame_code    = result_r.frame_code;
  assign out_resend        = result_r.resend;
  assign out_payload_count = result_r.payload_count;

endmodule

`default_nettype wire

// ===== tb/checksummed_frame_receiver_top_test.sv =====
// ----------------------------------------------------------------------------
// checksummed_frame_receiver_top_test
// Self-checking testbench for the checksummed frame receiver.
// ----------------------------------------------------------------------------
// Streams directed and random byte sequences into the receiver. Most of them
// are well-formed frames with random content. The rest are noise, truncated
// frames and oversize lengths. A cycle-free frame decoder in the testbench
// predicts one result word per accepted byte. Each result word is compared
// field by field against the oldest prediction. Both channels idle in random
// bursts.
// ----------------------------------------------------------------------------

module checksummed_frame_receiver_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_ITEMS  = 1200;
  localparam int CALM_TAIL  = 150;   // no idling once this few bytes remain

  logic       clk               = 1'b0;
  logic       rst_n             = 1'b0;
  logic       in_valid          = 1'b0;
  logic       in_ready;
  logic [7:0] in_rx_byte        = 8'h00;
  logic       out_valid;
  logic       out_ready         = 1'b0;
  logic       out_ack;
  logic       out_checksum_bad;
  logic [6:0] out_frame_code;
  logic       out_resend;
  logic [7:0] out_payload_count;

  checksummed_frame_receiver_top uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_ack           (out_ack),
    .out_checksum_bad  (out_checksum_bad),
    .out_frame_code    (out_frame_code),
    .out_resend        (out_resend),
    .out_payload_count (out_payload_count)
  );

  always #5 clk = ~clk;

  logic [7:0]       tx_bytes[$];
  cfr_pkg::result_t expected_results[$];
  int               error_count = 0;
  logic             in_fire     = 1'b0;

  // decoder state
  cfr_pkg::phase_t rx_phase  = cfr_pkg::PH_HEADER;
  logic [7:0]      rx_header = 8'h00;
  logic [7:0]      rx_len    = 8'h00;
  logic [7:0]      rx_seen   = 8'h00;
  logic [7:0]      rx_sum    = 8'h00;

  task automatic flag_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic void drop_frame();
    rx_phase  = cfr_pkg::PH_HEADER;
    rx_header = 8'h00;
    rx_len    = 8'h00;
    rx_seen   = 8'h00;
    rx_sum    = 8'h00;
  endfunction

  function automatic cfr_pkg::result_t close_frame(input logic [7:0] b);
    cfr_pkg::result_t r;
    r = '0;
    if (b == rx_sum) begin
      r.ack           = 1'b1;
      r.frame_code    = rx_header[6:0];
      r.resend        = rx_header[7];
      r.payload_count = rx_len;
    end else begin
      r.checksum_bad  = 1'b1;
    end
    drop_frame();
    return r;
  endfunction

  function automatic cfr_pkg::result_t decode_byte(input logic [7:0] b);
    cfr_pkg::result_t r;
    logic [6:0]       code;
    r    = '0;
    code = b[6:0];
    case (rx_phase)
      cfr_pkg::PH_HEADER: begin
        if (code == cfr_pkg::HDR_NUL || code == cfr_pkg::HDR_EOT ||
            code == cfr_pkg::HDR_BEL || code == cfr_pkg::HDR_ETB ||
            code >= cfr_pkg::HDR_PRINT) begin
          drop_frame();
          rx_header = b;
          rx_sum    = b;
          rx_phase  = (code >= cfr_pkg::HDR_VAR) ? cfr_pkg::PH_LENGTH
                                                 : cfr_pkg::PH_FIXED_SUM;
        end
      end
      cfr_pkg::PH_FIXED_SUM: r = close_frame(b);
      cfr_pkg::PH_LENGTH: begin
        if (int'(b) >= cfr_pkg::LEN_LIMIT) begin
          drop_frame();
        end else begin
          rx_len   = b;
          rx_seen  = 8'h00;
          rx_sum   = rx_sum + b;
          rx_phase = cfr_pkg::PH_PAYLOAD;
        end
      end
      default: begin
        if (rx_seen < rx_len) begin
          rx_sum  = rx_sum + b;
          rx_seen = rx_seen + 8'd1;
        end else begin
          r = close_frame(b);
        end
      end
    endcase
    return r;
  endfunction

  // keep < 0: whole frame; otherwise stop after keep bytes
  task automatic add_frame(input logic [7:0] hdr, input int len, input bit good,
                           input int keep);
    logic [7:0] sum;
    logic [7:0] b;
    int         start;
    int         i;
    start = tx_bytes.size();
    sum   = hdr;
    tx_bytes.push_back(hdr);
    if (keep >= 0 && tx_bytes.size() - start >= keep) return;
    if (hdr[6:0] >= cfr_pkg::HDR_VAR) begin
      tx_bytes.push_back(len[7:0]);
      sum = sum + len[7:0];
      if (keep >= 0 && tx_bytes.size() - start >= keep) return;
      for (i = 0; i < len; i++) begin
        b = 8'($urandom_range(0, 255));
        tx_bytes.push_back(b);
        sum = sum + b;
        if (keep >= 0 && tx_bytes.size() - start >= keep) return;
      end
    end
    tx_bytes.push_back(good ? sum : sum + 8'($urandom_range(1, 255)));
  endtask

  function automatic logic [7:0] pick_header();
    logic [6:0] code;
    case ($urandom_range(0, 3))
      0: begin
        case ($urandom_range(0, 3))
          0: code = cfr_pkg::HDR_NUL;
          1: code = cfr_pkg::HDR_EOT;
          2: code = cfr_pkg::HDR_BEL;
          default: code = cfr_pkg::HDR_ETB;
        endcase
      end
      1: code = 7'($urandom_range(cfr_pkg::HDR_PRINT, cfr_pkg::HDR_VAR - 1));
      default: code = 7'($urandom_range(cfr_pkg::HDR_VAR, 127));
    endcase
    return {1'($urandom_range(0, 1)), code};
  endfunction

  task automatic build_stream();
    int len;
    int pick;
    // directed part
    add_frame(8'h00, 0, 1'b1, -1);
    add_frame(8'hff, 0, 1'b1, -1);
    add_frame(8'h80, 0, 1'b0, -1);
    tx_bytes.push_back(8'h01);            // invalid headers are dropped
    tx_bytes.push_back(8'h9f);
    add_frame(8'h17, 0, 1'b1, -1);
    add_frame(8'h87, 0, 1'b1, -1);
    tx_bytes.push_back(8'h04);            // bad checksum that looks like a header
    tx_bytes.push_back(8'h20);
    add_frame(8'h20, 0, 1'b1, -1);
    add_frame(8'h5f, 0, 1'b1, -1);
    add_frame(8'he0, 3, 1'b1, -1);
    tx_bytes.push_back(8'h60);            // length at the limit is refused
    tx_bytes.push_back(8'(cfr_pkg::LEN_LIMIT));
    tx_bytes.push_back(8'h7f);
    tx_bytes.push_back(8'hff);
    // longest accepted payload
    add_frame(8'h7f, cfr_pkg::LEN_LIMIT - 1, 1'b1, -1);

    while (tx_bytes.size() < NUM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        len = ($urandom_range(0, 59) == 0) ?
              $urandom_range(100, cfr_pkg::LEN_LIMIT - 1) : $urandom_range(0, 6);
        add_frame(pick_header(), len, $urandom_range(0, 9) != 0, -1);
      end else if (pick < 78) begin
        add_frame({1'($urandom_range(0, 1)), 7'($urandom_range(cfr_pkg::HDR_VAR, 127))},
                  $urandom_range(cfr_pkg::LEN_LIMIT, 255), 1'b1, 2);
      end else if (pick < 90) begin
        add_frame(pick_header(), $urandom_range(1, 6), 1'b1, $urandom_range(1, 4));
      end else begin
        tx_bytes.push_back(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // input driver
  int in_gap   = 0;
  int in_quiet = 0;

  always @(negedge clk) begin
    logic       nv;
    logic [7:0] nb;
    logic       calm;
    logic       idle;
    nv   = in_valid;
    nb   = in_rx_byte;
    calm = tx_bytes.size() < CALM_TAIL;
    idle = 1'b0;
    if (!rst_n) begin
      nv = 1'b0;
    end else if (!in_valid || in_fire) begin
      nv = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
      end else if (tx_bytes.size() > 0) begin
        if (in_quiet > 0) begin
          in_quiet--;
        end else if (!calm && $urandom_range(0, 39) == 0) begin
          in_quiet = $urandom_range(30, 100);
        end else if (!calm && $urandom_range(0, 4) == 0) begin
          in_gap = $urandom_range(0, 10);   // this cycle is the first idle one
          idle   = 1'b1;
        end
        if (!idle) begin
          nv = 1'b1;
          nb = tx_bytes.pop_front();
        end
      end
    end
    in_valid   <= nv;
    in_rx_byte <= nb;
  end

  // result-side backpressure
  int out_gap   = 0;
  int out_quiet = 0;

  always @(negedge clk) begin
    logic calm;
    calm = tx_bytes.size() < CALM_TAIL;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_ready <= 1'b0;
    end else if (out_quiet > 0) begin
      out_quiet--;
      out_ready <= 1'b1;
    end else if (!calm && $urandom_range(0, 39) == 0) begin
      out_quiet = $urandom_range(30, 100);
      out_ready <= 1'b1;
    end else if (!calm && $urandom_range(0, 4) == 0) begin
      out_gap = $urandom_range(0, 10);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // monitor: check result words, then predict for the accepted byte
  always @(posedge clk) begin
    cfr_pkg::result_t seen;
    cfr_pkg::result_t want;
    in_fire <= rst_n && in_valid && in_ready;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        seen = {out_ack, out_checksum_bad, out_frame_code, out_resend,
                out_payload_count};
        if (expected_results.size() == 0) begin
          flag_mismatch($sformatf("unexpected result word %h", seen));
        end else begin
          want = expected_results.pop_front();
          if (seen.ack != want.ack)
            flag_mismatch($sformatf("ack %b, want %b", seen.ack, want.ack));
          if (seen.checksum_bad != want.checksum_bad)
            flag_mismatch($sformatf("checksum_bad %b, want %b",
                                    seen.checksum_bad, want.checksum_bad));
          if (seen.frame_code != want.frame_code)
            flag_mismatch($sformatf("frame_code %h, want %h",
                                    seen.frame_code, want.frame_code));
          if (seen.resend != want.resend)
            flag_mismatch($sformatf("resend %b, want %b", seen.resend, want.resend));
          if (seen.payload_count != want.payload_count)
            flag_mismatch($sformatf("payload_count %0d, want %0d",
                                    seen.payload_count, want.payload_count));
        end
      end
      if (in_valid && in_ready)
        expected_results.push_back(decode_byte(in_rx_byte));
    end
  end

  initial begin
    build_stream();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    while (tx_bytes.size() > 0 || in_valid) @(posedge clk);
    while (expected_results.size() > 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (expected_results.size() > 0)
      flag_mismatch($sformatf("%0d result words never arrived",
                              expected_results.size()));
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[%0t] timeout", $realtime);
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/cfr_pkg.sv
hw/rtl/checksummed_frame_receiver_top.sv
tb/checksummed_frame_receiver_top_test.sv
